FILE: hw/rtl/bfs_pkg.sv
`timescale 1ns / 1ps

package bfs_pkg;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_STEP    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [3:0] OP_PTR_INC = 4'd0;
  localparam logic [3:0] OP_PTR_DEC = 4'd1;
  localparam logic [3:0] OP_VAL_INC = 4'd2;
  localparam logic [3:0] OP_VAL_DEC = 4'd3;
  localparam logic [3:0] OP_PRINT   = 4'd4;
  localparam logic [3:0] OP_INPUT   = 4'd5;
  localparam logic [3:0] OP_OPEN    = 4'd6;
  localparam logic [3:0] OP_CLOSE   = 4'd7;
  localparam logic [3:0] OP_ZERO    = 4'd8;
  localparam logic [3:0] OP_DONE    = 4'd9;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OOB    = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_LOADED = 2'd3;

  localparam int OPCODE_W  = 4;
  localparam int OPERAND_W = 16;

  typedef struct packed {
    logic [1:0] status;
    logic       print_valid;
    logic       input_taken;
    logic       cell_we;
    logic       ptr_move;
  } step_ctl_t;

endpackage

FILE: hw/rtl/bfs_if.sv
`timescale 1ns / 1ps

interface bfs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] load_addr;
  logic [3:0]  load_opcode;
  logic [15:0] load_operand;
  logic [7:0]  input_byte;

  modport source(output valid, output kind, output load_addr, output load_opcode,
                 output load_operand, output input_byte, input ready);
  modport sink(input valid, input kind, input load_addr, input load_opcode,
               input load_operand, input input_byte, output ready);
endinterface

interface bfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        print_valid;
  logic [7:0]  print_value;
  logic        input_taken;
  logic [11:0] program_counter;
  logic        is_done;

  modport source(output valid, output status, output print_valid, output print_value,
                 output input_taken, output program_counter, output is_done,
                 input ready);
  modport sink(input valid, input status, input print_valid, input print_value,
               input input_taken, input program_counter, input is_done,
               output ready);
endinterface

FILE: hw/rtl/brainfuck_bytecode_step_top.sv
`timescale 1ns / 1ps
// Run-length bytecode engine with a program memory and a cell memory.
// in_ch carries one transaction per item: kind selects load (write one
// instruction word at load_addr), step (execute the word at pc, using
// input_byte for an input instruction) or restart (clear cells, pointer, pc).
// out_ch returns exactly one result transaction per item: status, print data,
// whether input_byte was consumed, the new pc and whether the word there is done.
// Only one item is in flight: in_ch.ready stays low until its result is
// registered. The accept cycle executes against the cached instruction word and
// current cell; the response state then registers the result and takes in the
// program memory read at the new pc and, after a pointer move, the cell memory
// read at the new pointer.
// Reset and every restart start a clearing pass that writes zero to the cell
// memory, one cell a cycle, through all CELL_COUNT cells; in_ch.ready stays low
// until it ends. The program memory keeps its contents across restart.
// A stalled receiver holds the result in the output register; the next item is
// taken once that result is taken, in the same cycle at the earliest.
module brainfuck_bytecode_step_top
  import bfs_pkg::*;
#(
  parameter int PROG_DEPTH = 4096,
  parameter int CELL_COUNT = 32768,
  parameter int CELL_BITS  = 8
) (
  input logic      clk,
  input logic      rst_n,
  bfs_in_if.sink   in_ch,
  bfs_out_if.source out_ch
);

  localparam int PA_W   = $clog2(PROG_DEPTH);
  localparam int CI_W   = $clog2(CELL_COUNT);
  localparam int WORD_W = PA_W + OPCODE_W + OPERAND_W;
  localparam int MOD_SH = OPERAND_W + PA_W;
  localparam logic [17:0] MOD_M =
    18'(((64'd1 << MOD_SH) + 64'(PROG_DEPTH) - 64'd1) / 64'(PROG_DEPTH));

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RESP} state_t;

  state_t               state_r;
  logic [PA_W-1:0]      pc_r;
  logic [CI_W-1:0]      ci_r;
  logic [CELL_BITS-1:0] cell_r;
  logic [CI_W-1:0]      clr_cnt_r;
  logic [OPCODE_W-1:0]  cur_op_r;
  logic [OPERAND_W-1:0] cur_arg_r;
  logic [PA_W-1:0]      cur_tgt_r;

  logic [1:0]           kind_r;
  logic                 ptr_move_r;
  logic                 laddr_ok_r;
  logic [PA_W-1:0]      laddr_r;
  logic [OPCODE_W-1:0]  lop_r;
  logic [OPERAND_W-1:0] larg_r;
  logic [OPERAND_W-1:0] lq_r;
  logic [1:0]           status_r;
  logic                 pvalid_r;
  logic [7:0]           pvalue_r;
  logic                 itaken_r;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic                 out_pvalid_r;
  logic [7:0]           out_pvalue_r;
  logic                 out_itaken_r;
  logic [11:0]          out_pc_r;
  logic                 out_done_r;

  logic [WORD_W-1:0]    prog_mem [PROG_DEPTH];
  logic [WORD_W-1:0]    prog_rdata_r;
  logic [CELL_BITS-1:0] cell_mem [CELL_COUNT];
  logic [CELL_BITS-1:0] cell_rdata_r;

  logic                 in_fire;
  logic                 step_fire;
  logic                 restart_fire;
  step_ctl_t            alu_ctl;
  logic [PA_W-1:0]      alu_pc_nxt;
  logic [CI_W-1:0]      alu_ci_nxt;
  logic [CELL_BITS-1:0] alu_cell_wdata;

  logic                 prog_we;
  logic [PA_W-1:0]      prog_raddr;
  logic [WORD_W-1:0]    prog_wdata;
  logic                 cell_we;
  logic [CI_W-1:0]      cell_waddr;
  logic [CELL_BITS-1:0] cell_wdata;

  logic [33:0]          lq_prod;
  logic [OPERAND_W-1:0] lq_nxt;
  logic [31:0]          lqd;
  logic [OPERAND_W-1:0] lrem;
  logic [OPERAND_W-1:0] lrem_fix;
  logic [PA_W-1:0]      ltgt;
  logic                 laddr_ok_nxt;

  logic [OPCODE_W-1:0]  cur_op_nxt;
  logic [OPERAND_W-1:0] cur_arg_nxt;
  logic [PA_W-1:0]      cur_tgt_nxt;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign step_fire    = in_fire && (in_ch.kind == KIND_STEP);
  assign restart_fire = in_fire && (in_ch.kind == KIND_RESTART);

  bfs_step_alu #(
    .PROG_DEPTH(PROG_DEPTH),
    .CELL_COUNT(CELL_COUNT),
    .CELL_BITS (CELL_BITS)
  ) u_alu (
    .op        (cur_op_r),
    .arg       (cur_arg_r),
    .tgt       (cur_tgt_r),
    .pc        (pc_r),
    .ci        (ci_r),
    .cell_val  (cell_r),
    .input_byte(in_ch.input_byte),
    .ctl       (alu_ctl),
    .pc_nxt    (alu_pc_nxt),
    .ci_nxt    (alu_ci_nxt),
    .cell_wdata(alu_cell_wdata)
  );

  // bracket target reduced modulo PROG_DEPTH: reciprocal quotient now, remainder next cycle
  assign lq_prod      = 34'(in_ch.load_operand) * 34'(MOD_M);
  assign lq_nxt       = OPERAND_W'(lq_prod >> MOD_SH);
  assign laddr_ok_nxt = 32'(in_ch.load_addr) < 32'(PROG_DEPTH);
  assign lqd          = 32'(lq_r) * 32'(PROG_DEPTH);
  assign lrem         = OPERAND_W'(32'(larg_r) - lqd);
  assign lrem_fix     = ((OPERAND_W + 1)'(lrem) >= (OPERAND_W + 1)'(PROG_DEPTH)) ?
                        OPERAND_W'((OPERAND_W + 1)'(lrem) - (OPERAND_W + 1)'(PROG_DEPTH)) :
                        lrem;
  assign ltgt         = PA_W'(lrem_fix);

  assign prog_we    = (state_r == S_RESP) && (kind_r == KIND_LOAD) && laddr_ok_r;
  assign prog_wdata = {ltgt, lop_r, larg_r};
  assign prog_raddr = restart_fire ? '0 : alu_pc_nxt;

  assign cell_we    = (state_r == S_CLEAR) || (step_fire && alu_ctl.cell_we);
  assign cell_waddr = (state_r == S_CLEAR) ? clr_cnt_r : ci_r;
  assign cell_wdata = (state_r == S_CLEAR) ? '0 : alu_cell_wdata;

  always_ff @(posedge clk) begin
    if (prog_we) prog_mem[laddr_r] <= prog_wdata;
    prog_rdata_r <= prog_mem[prog_raddr];
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_rdata_r <= cell_mem[alu_ci_nxt];
  end

  always_comb begin
    cur_op_nxt  = cur_op_r;
    cur_arg_nxt = cur_arg_r;
    cur_tgt_nxt = cur_tgt_r;
    case (kind_r) inside
      KIND_STEP, KIND_RESTART: begin
        {cur_tgt_nxt, cur_op_nxt, cur_arg_nxt} = prog_rdata_r;
      end
      KIND_LOAD: begin
        if (laddr_ok_r && (laddr_r == pc_r)) begin
          cur_tgt_nxt = ltgt;
          cur_op_nxt  = lop_r;
          cur_arg_nxt = larg_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      ci_r        <= '0;
      cell_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + CI_W'(1);
          if (clr_cnt_r == CI_W'(CELL_COUNT - 1)) begin
            clr_cnt_r <= '0;
            state_r   <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state_r    <= S_RESP;
            kind_r     <= in_ch.kind;
            ptr_move_r <= 1'b0;
            laddr_ok_r <= laddr_ok_nxt;
            laddr_r    <= PA_W'(in_ch.load_addr);
            lop_r      <= in_ch.load_opcode;
            larg_r     <= in_ch.load_operand;
            lq_r       <= lq_nxt;
            status_r   <= ST_OK;
            pvalid_r   <= 1'b0;
            pvalue_r   <= '0;
            itaken_r   <= 1'b0;
            case (in_ch.kind)
              KIND_LOAD: status_r <= ST_LOADED;
              KIND_STEP: begin
                pc_r       <= alu_pc_nxt;
                ci_r       <= alu_ci_nxt;
                ptr_move_r <= alu_ctl.ptr_move;
                status_r   <= alu_ctl.status;
                pvalid_r   <= alu_ctl.print_valid;
                itaken_r   <= alu_ctl.input_taken;
                if (alu_ctl.print_valid) pvalue_r <= cell_r[7:0];
                if (alu_ctl.cell_we) cell_r <= alu_cell_wdata;
              end
              KIND_RESTART: begin
                pc_r   <= '0;
                ci_r   <= '0;
                cell_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RESP: begin
          state_r      <= (kind_r == KIND_RESTART) ? S_CLEAR : S_IDLE;
          if (ptr_move_r) cell_r <= cell_rdata_r;
          cur_op_r     <= cur_op_nxt;
          cur_arg_r    <= cur_arg_nxt;
          cur_tgt_r    <= cur_tgt_nxt;
          out_valid_r  <= 1'b1;
          out_status_r <= status_r;
          out_pvalid_r <= pvalid_r;
          out_pvalue_r <= pvalue_r;
          out_itaken_r <= itaken_r;
          out_pc_r     <= 12'(pc_r);
          out_done_r   <= cur_op_nxt == OP_DONE;
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.print_valid     = out_pvalid_r;
  assign out_ch.print_value     = out_pvalue_r;
  assign out_ch.input_taken     = out_itaken_r;
  assign out_ch.program_counter = out_pc_r;
  assign out_ch.is_done         = out_done_r;

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_fire)
    else $error("input accepted while an item is in flight");

  a_result_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_fire, 2))
    else $error("result appeared without an accepted item");

  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PA_W'(PROG_DEPTH - 1))
    else $error("pc outside program memory");

  a_move_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |-> !(alu_ctl.cell_we && alu_ctl.ptr_move))
    else $error("pointer move collides with cell write");

  a_load_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.kind == KIND_LOAD)) |=> $stable(pc_r))
    else $error("load transaction changed pc");
`endif

endmodule

FILE: hw/rtl/bfs_step_alu.sv
`timescale 1ns / 1ps

module bfs_step_alu
  import bfs_pkg::*;
#(
  parameter int PROG_DEPTH = 4096,
  parameter int CELL_COUNT = 32768,
  parameter int CELL_BITS  = 8,
  localparam int PA_W = $clog2(PROG_DEPTH),
  localparam int CI_W = $clog2(CELL_COUNT)
) (
  input  logic [OPCODE_W-1:0]  op,
  input  logic [OPERAND_W-1:0] arg,
  input  logic [PA_W-1:0]      tgt,
  input  logic [PA_W-1:0]      pc,
  input  logic [CI_W-1:0]      ci,
  input  logic [CELL_BITS-1:0] cell_val,
  input  logic [7:0]           input_byte,
  output step_ctl_t            ctl,
  output logic [PA_W-1:0]      pc_nxt,
  output logic [CI_W-1:0]      ci_nxt,
  output logic [CELL_BITS-1:0] cell_wdata
);

  logic [PA_W-1:0]      pc_inc;
  logic [OPERAND_W:0]   ptr_sum;
  logic                 inc_oob;
  logic                 dec_oob;
  logic                 cell_zero;

  assign pc_inc    = (pc == PA_W'(PROG_DEPTH - 1)) ? '0 : pc + PA_W'(1);
  assign ptr_sum   = (OPERAND_W + 1)'(ci) + (OPERAND_W + 1)'(arg);
  assign inc_oob   = ptr_sum >= (OPERAND_W + 1)'(CELL_COUNT);
  assign dec_oob   = arg > OPERAND_W'(ci);
  assign cell_zero = cell_val == '0;

  always_comb begin
    ctl        = '0;
    ctl.status = ST_OK;
    pc_nxt     = pc_inc;
    ci_nxt     = ci;
    cell_wdata = cell_val;
    unique case (op)
      OP_PTR_INC: begin
        if (inc_oob) begin
          ctl.status = ST_OOB;
          pc_nxt     = pc;
        end else begin
          ci_nxt       = CI_W'(ptr_sum);
          ctl.ptr_move = 1'b1;
        end
      end
      OP_PTR_DEC: begin
        if (dec_oob) begin
          ctl.status = ST_OOB;
          pc_nxt     = pc;
        end else begin
          ci_nxt       = ci - CI_W'(arg);
          ctl.ptr_move = 1'b1;
        end
      end
      OP_VAL_INC: begin
        cell_wdata  = cell_val + CELL_BITS'(arg);
        ctl.cell_we = 1'b1;
      end
      OP_VAL_DEC: begin
        cell_wdata  = cell_val - CELL_BITS'(arg);
        ctl.cell_we = 1'b1;
      end
      OP_PRINT: ctl.print_valid = 1'b1;
      OP_INPUT: begin
        cell_wdata      = CELL_BITS'(input_byte);
        ctl.cell_we     = 1'b1;
        ctl.input_taken = 1'b1;
      end
      OP_OPEN: begin
        if (cell_zero) pc_nxt = tgt;
      end
      OP_CLOSE: begin
        if (!cell_zero) pc_nxt = tgt;
      end
      OP_ZERO: begin
        cell_wdata  = '0;
        ctl.cell_we = 1'b1;
      end
      OP_DONE: begin
        ctl.status = ST_DONE;
        pc_nxt     = pc;
      end
      default: ;
    endcase
  end

endmodule

FILE: verif/brainfuck_bytecode_step_top_tb.sv
`timescale 1ns / 1ps

module brainfuck_bytecode_step_top_tb;
  import bfs_pkg::*;

  localparam int          CYCLE_LIMIT    = 2_000_000;
  localparam int          ITEMS_PER_LEG  = 340;
  localparam logic [1:0]  KIND_UNUSED    = 2'd3;
  localparam logic [3:0]  OP_SPARE_LAST  = 4'd15;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] load_addr;
    logic [3:0]  load_opcode;
    logic [15:0] load_operand;
    logic [7:0]  input_byte;
  } bfs_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        print_valid;
    logic [7:0]  print_value;
    logic        input_taken;
    logic [11:0] program_counter;
    logic        is_done;
  } bfs_result_t;

  class bfs_scoreboard;
    localparam int PROG_WORDS = 4096;
    localparam int CELL_TOTAL = 32768;

    logic [19:0]  prog_words [PROG_WORDS];
    bit           prog_written [PROG_WORDS];
    logic [7:0]   cells [CELL_TOTAL];
    logic [11:0]  pc_q;
    logic [14:0]  ptr_q;
    bfs_result_t  pending_results [$];
    int           mismatches;
    int           item_count;
    int           n_loads, n_steps, n_restarts, n_prints, n_inputs, n_oob, n_done;

    function new();
      foreach (prog_words[i]) begin
        prog_words[i] = '0;
        prog_written[i] = 1'b0;
      end
      foreach (cells[i]) cells[i] = '0;
      pc_q = '0;
      ptr_q = '0;
      mismatches = 0;
      item_count = 0;
      n_loads = 0; n_steps = 0; n_restarts = 0; n_prints = 0;
      n_inputs = 0; n_oob = 0; n_done = 0;
    endfunction

    function bfs_result_t execute_item(bfs_item_t it, bit commit);
      bfs_result_t r;
      logic [19:0] w;
      logic [3:0]  op;
      logic [15:0] arg;
      logic [7:0]  cell_v;
      logic [7:0]  cell_n;
      logic [11:0] nxt;
      logic [14:0] ptr_n;
      bit          cell_we;
      r = '0;
      nxt = pc_q;
      ptr_n = ptr_q;
      cell_we = 1'b0;
      cell_n = '0;
      case (it.kind)
        KIND_LOAD: begin
          r.status = ST_LOADED;
          if (commit) begin
            prog_words[it.load_addr] = {it.load_opcode, it.load_operand};
            prog_written[it.load_addr] = 1'b1;
          end
        end
        KIND_RESTART: begin
          nxt = '0;
          ptr_n = '0;
          if (commit) foreach (cells[i]) cells[i] = '0;
        end
        KIND_STEP: begin
          w = prog_words[pc_q];
          op = w[19:16];
          arg = w[15:0];
          cell_v = cells[ptr_q];
          nxt = pc_q + 12'd1;
          case (op)
            OP_PTR_INC: begin
              if (int'(ptr_q) + int'(arg) >= CELL_TOTAL) begin
                r.status = ST_OOB;
                nxt = pc_q;
              end else begin
                ptr_n = ptr_q + arg[14:0];
              end
            end
            OP_PTR_DEC: begin
              if (int'(arg) > int'(ptr_q)) begin
                r.status = ST_OOB;
                nxt = pc_q;
              end else begin
                ptr_n = ptr_q - arg[14:0];
              end
            end
            OP_VAL_INC: begin
              cell_we = 1'b1;
              cell_n = cell_v + arg[7:0];
            end
            OP_VAL_DEC: begin
              cell_we = 1'b1;
              cell_n = cell_v - arg[7:0];
            end
            OP_PRINT: begin
              r.print_valid = 1'b1;
              r.print_value = cell_v;
            end
            OP_INPUT: begin
              cell_we = 1'b1;
              cell_n = it.input_byte;
              r.input_taken = 1'b1;
            end
            OP_OPEN: if (cell_v == 8'd0) nxt = arg[11:0];
            OP_CLOSE: if (cell_v != 8'd0) nxt = arg[11:0];
            OP_ZERO: begin
              cell_we = 1'b1;
              cell_n = '0;
            end
            OP_DONE: begin
              r.status = ST_DONE;
              nxt = pc_q;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (commit) begin
        if (cell_we) cells[ptr_q] = cell_n;
        ptr_q = ptr_n;
        pc_q = nxt;
      end
      r.program_counter = nxt;
      r.is_done = (prog_words[nxt][19:16] == OP_DONE);
      return r;
    endfunction

    function logic [11:0] peek_pc(bfs_item_t it);
      bfs_result_t r;
      r = execute_item(it, 1'b0);
      return r.program_counter;
    endfunction

    function bit is_written(logic [11:0] addr);
      return prog_written[addr];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_item(bfs_item_t it);
      bfs_result_t r;
      r = execute_item(it, 1'b1);
      pending_results.push_back(r);
      item_count++;
      case (it.kind)
        KIND_LOAD: n_loads++;
        KIND_STEP: n_steps++;
        KIND_RESTART: n_restarts++;
        default: ;
      endcase
      if (r.print_valid) n_prints++;
      if (r.input_taken) n_inputs++;
      if (it.kind == KIND_STEP && r.status == ST_OOB) n_oob++;
      if (it.kind == KIND_STEP && r.status == ST_DONE) n_done++;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(bfs_result_t got);
      bfs_result_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status)
        report_mismatch($sformatf("status got %0d exp %0d", got.status, exp.status));
      if (got.print_valid !== exp.print_valid)
        report_mismatch($sformatf("print_valid got %0b exp %0b",
                                  got.print_valid, exp.print_valid));
      if (got.print_value !== exp.print_value)
        report_mismatch($sformatf("print_value got %0h exp %0h",
                                  got.print_value, exp.print_value));
      if (got.input_taken !== exp.input_taken)
        report_mismatch($sformatf("input_taken got %0b exp %0b",
                                  got.input_taken, exp.input_taken));
      if (got.program_counter !== exp.program_counter)
        report_mismatch($sformatf("program_counter got %0h exp %0h",
                                  got.program_counter, exp.program_counter));
      if (got.is_done !== exp.is_done)
        report_mismatch($sformatf("is_done got %0b exp %0b", got.is_done, exp.is_done));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int unsigned src_idle_pct = 27;
  int unsigned sink_idle_pct = 48;
  int cycle_count;
  int restarts_left;
  bfs_scoreboard sb;

  bfs_in_if  in_ch ();
  bfs_out_if out_ch ();

  brainfuck_bytecode_step_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bfs_result_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.status = out_ch.status;
        got.print_valid = out_ch.print_valid;
        got.print_value = out_ch.print_value;
        got.input_taken = out_ch.input_taken;
        got.program_counter = out_ch.program_counter;
        got.is_done = out_ch.is_done;
        sb.check_result(got);
      end
      out_ch.ready <= (rst_n === 1'b1) ? ($urandom_range(0, 99) >= sink_idle_pct) : 1'b0;
    end
  end

  function automatic bfs_item_t junk_item(input logic [1:0] kind);
    bfs_item_t it;
    it.kind = kind;
    it.load_addr = 12'($urandom);
    it.load_opcode = 4'($urandom);
    it.load_operand = 16'($urandom);
    it.input_byte = 8'($urandom);
    return it;
  endfunction

  function automatic logic [19:0] rand_word(input logic [11:0] base);
    logic [3:0]  op;
    logic [15:0] arg;
    logic [11:0] win;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    win = ($urandom_range(0, 9) == 0) ? 12'hFF8 : base;
    if (pick < 12) op = OP_PTR_INC;
    else if (pick < 22) op = OP_PTR_DEC;
    else if (pick < 36) op = OP_VAL_INC;
    else if (pick < 46) op = OP_VAL_DEC;
    else if (pick < 54) op = OP_PRINT;
    else if (pick < 62) op = OP_INPUT;
    else if (pick < 72) op = OP_OPEN;
    else if (pick < 82) op = OP_CLOSE;
    else if (pick < 88) op = OP_ZERO;
    else if (pick < 92) op = OP_DONE;
    else op = 4'(OP_DONE + $urandom_range(1, 6));
    case (op) inside
      OP_PTR_INC, OP_PTR_DEC:
        arg = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      OP_VAL_INC, OP_VAL_DEC:
        arg = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
      OP_OPEN, OP_CLOSE:
        arg = ($urandom_range(0, 6) == 0) ? 16'($urandom)
            : {4'($urandom), 12'(win + 12'($urandom_range(0, 15)))};
      default: arg = 16'($urandom);
    endcase
    return {op, arg};
  endfunction

  task automatic send_item(input bfs_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.load_addr <= it.load_addr;
    in_ch.load_opcode <= it.load_opcode;
    in_ch.load_operand <= it.load_operand;
    in_ch.input_byte <= it.input_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(it);
  endtask

  task automatic load_word(input logic [11:0] addr, input logic [19:0] word);
    bfs_item_t it;
    it = junk_item(KIND_LOAD);
    it.load_addr = addr;
    it.load_opcode = word[19:16];
    it.load_operand = word[15:0];
    send_item(it);
  endtask

  // Fill the word at the pc this step lands on, so no unwritten word is fetched.
  task automatic step_once(input logic [7:0] ibyte);
    bfs_item_t it;
    logic [11:0] nxt;
    it = junk_item(KIND_STEP);
    it.input_byte = ibyte;
    nxt = sb.peek_pc(it);
    if (!sb.is_written(nxt)) load_word(nxt, rand_word(nxt));
    send_item(it);
  endtask

  task automatic exec_word(input logic [3:0] op, input logic [15:0] arg,
                           input logic [7:0] ibyte);
    load_word(sb.pc_q, {op, arg});
    step_once(ibyte);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    load_word(12'd0, {OP_VAL_INC, 16'hFFFF});
    step_once(8'h00);
    exec_word(OP_PRINT, 16'h0000, 8'hFF);
    exec_word(OP_INPUT, 16'hFFFF, 8'hFF);
    exec_word(OP_VAL_DEC, 16'h0101, 8'h00);
    exec_word(OP_CLOSE, 16'hFFFF, 8'h00);
    exec_word(OP_VAL_INC, 16'h0002, 8'h00);
    exec_word(OP_OPEN, 16'hF005, 8'h00);
    exec_word(OP_ZERO, 16'h0000, 8'h00);
    exec_word(OP_PTR_INC, 16'd32767, 8'h00);
    exec_word(OP_PTR_INC, 16'd1, 8'h00);
    exec_word(OP_PTR_DEC, 16'hFFFF, 8'h00);
    exec_word(OP_PTR_DEC, 16'd32767, 8'h00);
    exec_word(OP_SPARE_LAST, 16'h0000, 8'h00);
    exec_word(OP_DONE, 16'h0000, 8'h00);
    step_once(8'h00);
    send_item(junk_item(KIND_UNUSED));
    send_item(junk_item(KIND_RESTART));
  endtask

  task automatic run_random(input int count);
    int start;
    int pick;
    int len;
    logic [11:0] base;
    logic [15:0] arg;
    start = sb.item_count;
    while (sb.item_count - start < count) begin
      pick = $urandom_range(0, 99);
      if (restarts_left > 0 && $urandom_range(0, 149) == 0) begin
        restarts_left--;
        send_item(junk_item(KIND_RESTART));
      end else if (pick < 55) begin
        base = sb.pc_q;
        len = $urandom_range(2, 12);
        repeat (len) load_word(12'(base + 12'($urandom_range(0, 15))), rand_word(base));
        len = $urandom_range(5, 40);
        repeat (len) step_once(8'($urandom));
      end else if (pick < 72) begin
        load_word(12'($urandom), rand_word(12'($urandom)));
      end else if (pick < 88) begin
        len = $urandom_range(1, 8);
        repeat (len) step_once(8'($urandom));
      end else if (pick < 93) begin
        send_item(junk_item(KIND_UNUSED));
      end else if ($urandom_range(0, 1) == 0) begin
        arg = 16'(32767 - int'(sb.ptr_q) + int'($urandom_range(0, 1)));
        exec_word(OP_PTR_INC, arg, 8'($urandom));
      end else begin
        arg = 16'(int'(sb.ptr_q) + int'($urandom_range(0, 1)));
        exec_word(OP_PTR_DEC, arg, 8'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    restarts_left = 8;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.load_addr = '0;
    in_ch.load_opcode = OP_PTR_INC;
    in_ch.load_operand = '0;
    in_ch.input_byte = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();
    run_random(ITEMS_PER_LEG);
    drain();

    src_idle_pct = 48;
    sink_idle_pct = 27;
    run_random(ITEMS_PER_LEG);
    drain();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_random(ITEMS_PER_LEG);
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d items: %0d loads, %0d steps, %0d restarts, in %0d cycles",
             sb.item_count, sb.n_loads, sb.n_steps, sb.n_restarts, cycle_count);
    $display("steps: %0d prints, %0d inputs, %0d pointer out of bounds, %0d at done",
             sb.n_prints, sb.n_inputs, sb.n_oob, sb.n_done);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
